@@ hw/rtl/aes_pkg.sv @@
// Package with AES types, codes, S-box tables and GF(2^8) helpers.
package aes_pkg;

    localparam logic [1:0] MODE_LOAD    = 2'd0;
    localparam logic [1:0] MODE_ENCRYPT = 2'd1;
    localparam logic [1:0] MODE_DECRYPT = 2'd2;

    localparam logic [3:0] ROUNDS_MIN = 4'd10;
    localparam logic [3:0] ROUNDS_MAX = 4'd14;
    localparam logic [7:0] GF_REDUCE  = 8'h1b;

    typedef struct packed {
        logic [1:0]  mode;
        logic [5:0]  key_index;
        logic [31:0] key_word;
        logic [63:0] block_high;
        logic [63:0] block_low;
    } aes_in_t;

    typedef struct packed {
        logic [63:0] result_high;
        logic [63:0] result_low;
    } aes_out_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic       load_state;
        logic       first_round;
        logic       middle_round;
        logic       final_round;
        logic       decrypt;
        logic [3:0] round;
    } aes_cmd_t;

    localparam logic [7:0] FWD_SBOX [256] = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };

    localparam logic [7:0] INV_SBOX [256] = '{
        8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
        8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
        8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
        8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
        8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
        8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
        8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
        8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
        8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
        8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
        8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
        8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
        8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
        8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
        8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
        8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d
    };

    // Multiply by two in GF(2^8).
    function automatic logic [7:0] xtime(input logic [7:0] x);
        xtime = {x[6:0], 1'b0} ^ (x[7] ? GF_REDUCE : 8'h00);
    endfunction

    // Forward MixColumns on one 32-bit column, row 0 in the top byte.
    function automatic logic [31:0] mix_fwd(input logic [31:0] col);
        logic [7:0] a0, a1, a2, a3;
        a0 = col[31:24];
        a1 = col[23:16];
        a2 = col[15:8];
        a3 = col[7:0];
        mix_fwd = {xtime(a0) ^ xtime(a1) ^ a1 ^ a2 ^ a3,
                   a0 ^ xtime(a1) ^ xtime(a2) ^ a2 ^ a3,
                   a0 ^ a1 ^ xtime(a2) ^ xtime(a3) ^ a3,
                   xtime(a0) ^ a0 ^ a1 ^ a2 ^ xtime(a3)};
    endfunction

    // Inverse MixColumns: premultiply by {05,00,04,00} circulant, then forward mix.
    function automatic logic [31:0] mix_inv(input logic [31:0] col);
        logic [7:0] a0, a1, a2, a3, u, v;
        a0 = col[31:24];
        a1 = col[23:16];
        a2 = col[15:8];
        a3 = col[7:0];
        u = xtime(xtime(a0 ^ a2));
        v = xtime(xtime(a1 ^ a3));
        mix_inv = mix_fwd({a0 ^ u, a1 ^ v, a2 ^ u, a3 ^ v});
    endfunction

endpackage

@@ hw/rtl/aes_ctrl.sv @@
// Round sequencer for the AES core.
module aes_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              start,
    input  logic              decrypt,
    input  logic [3:0]        rounds,
    input  logic              out_taken,
    output aes_pkg::aes_cmd_t cmd,
    output logic              busy,
    output logic              out_valid
);
    import aes_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_KEY  = 3'b010,
        ST_RUN  = 3'b100
    } state_t;

    state_t     state_reg, state_next;
    logic [3:0] round_reg, round_next;
    logic [3:0] nr_reg, nr_next;
    logic       dec_reg, dec_next;
    logic       out_valid_reg, out_valid_next;
    logic       last_round;
    logic       out_free;

    // The final round can only retire when the result register is free.
    assign last_round = (state_reg == ST_RUN) && (round_reg == nr_reg);
    assign out_free   = !out_valid_reg || out_taken;

    // Next state and round counter; ST_KEY adds the first round key, then
    // round counts up from 1 to nr and holds at nr while the result waits.
    always_comb begin
        state_next = state_reg;
        round_next = round_reg;
        nr_next    = nr_reg;
        dec_next   = dec_reg;
        case (state_reg)
            ST_IDLE: begin
                if (start) begin
                    state_next = ST_KEY;
                    round_next = 4'd0;
                    nr_next    = rounds;
                    dec_next   = decrypt;
                end
            end
            ST_KEY: begin
                state_next = ST_RUN;
                round_next = 4'd1;
            end
            ST_RUN: begin
                if (round_reg == nr_reg) begin
                    if (out_free) begin
                        state_next = ST_IDLE;
                    end
                end else begin
                    round_next = round_reg + 4'd1;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // The result register fills on the final round and empties when taken.
    always_comb begin
        out_valid_next = out_valid_reg;
        if (last_round && out_free) begin
            out_valid_next = 1'b1;
        end else if (out_taken) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            round_reg     <= 4'd0;
            nr_reg        <= ROUNDS_MIN;
            dec_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            round_reg     <= round_next;
            nr_reg        <= nr_next;
            dec_reg       <= dec_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Commands. The key read is registered, so the key index names the round
    // that runs in the next cycle: the round for encrypt, nr minus it for decrypt.
    always_comb begin
        cmd.load_state   = (state_reg == ST_IDLE) && start;
        cmd.first_round  = (state_reg == ST_KEY);
        cmd.middle_round = (state_reg == ST_RUN) && (round_reg != nr_reg);
        cmd.final_round  = last_round && out_free;
        cmd.decrypt      = dec_reg;
        cmd.round        = dec_next ? (nr_next - round_next) : round_next;
    end

    assign busy      = (state_reg != ST_IDLE);
    assign out_valid = out_valid_reg;
endmodule

@@ hw/rtl/aes_datapath.sv @@
// AES state register, round logic and round-key store.
module aes_datapath #(
    parameter int KEY_WORDS = 60
) (
    input  logic              aclk,
    input  logic              key_we,
    input  logic [5:0]        key_index,
    input  logic [31:0]       key_word,
    input  logic [127:0]      block_in,
    input  aes_pkg::aes_cmd_t cmd,
    output logic [127:0]      block_out
);
    import aes_pkg::*;

    localparam int KW = $clog2(KEY_WORDS / 4);

    // Four banks, one per column, so a round key is one read of each bank.
    logic [31:0]  key_mem [4][KEY_WORDS / 4];
    logic [127:0] rkey_reg;
    logic [127:0] state_reg, state_next;
    logic [127:0] out_reg;
    logic [127:0] sub_b, shf_b, mix_b, t;

    // Key store write and registered read of the round key for the next cycle.
    always_ff @(posedge aclk) begin
        if (key_we) begin
            key_mem[key_index[1:0]][key_index[KW+1:2]] <= key_word;
        end
        for (int c = 0; c < 4; c++) begin
            rkey_reg[127 - 32*c -: 32] <= key_mem[c][cmd.round[KW-1:0]];
        end
    end

    // Round function: byte 4c+r sits at bits 127-8(4c+r).
    always_comb begin
        for (int c = 0; c < 4; c++) begin
            for (int r = 0; r < 4; r++) begin
                shf_b[127 - 8*(4*c + r) -: 8] = cmd.decrypt ?
                    state_reg[127 - 8*(4*((c + 4 - r) % 4) + r) -: 8] :
                    state_reg[127 - 8*(4*((c + r) % 4) + r) -: 8];
            end
        end
        for (int i = 0; i < 16; i++) begin
            sub_b[127 - 8*i -: 8] = cmd.decrypt ? INV_SBOX[shf_b[127 - 8*i -: 8]] :
                                                  FWD_SBOX[shf_b[127 - 8*i -: 8]];
        end
        for (int c = 0; c < 4; c++) begin
            mix_b[127 - 32*c -: 32] = mix_fwd(sub_b[127 - 32*c -: 32]);
        end
        if (cmd.decrypt) begin
            t = sub_b ^ rkey_reg;
            for (int c = 0; c < 4; c++) begin
                mix_b[127 - 32*c -: 32] = mix_inv(t[127 - 32*c -: 32]);
            end
        end else begin
            t     = mix_b;
            mix_b = t ^ rkey_reg;
        end
    end

    // The block loads raw; the first round key is added in the next cycle.
    always_comb begin
        state_next = state_reg;
        if (cmd.load_state) begin
            state_next = block_in;
        end else if (cmd.first_round) begin
            state_next = state_reg ^ rkey_reg;
        end else if (cmd.middle_round) begin
            state_next = mix_b;
        end
    end

    always_ff @(posedge aclk) begin
        state_reg <= state_next;
    end

    // The final round writes straight into the result register.
    always_ff @(posedge aclk) begin
        if (cmd.final_round) begin
            out_reg <= sub_b ^ rkey_reg;
        end
    end

    assign block_out = out_reg;
endmodule

@@ hw/rtl/aes_block_cipher.sv @@
// Top level of the round-iterative AES block cipher.
// Usage:
//   The s_ channel carries one request per item: mode 0 writes one expanded
//   key word at key_index, mode 1 encrypts and mode 2 decrypts the block.
//   Load requests and mode 3 produce no result.
//   A cipher request loads the block, adds the first round key in the next
//   cycle and then runs one round per cycle in a single shared round unit,
//   except that the final round waits while the result register is full.
//   m_valid rises once the final round has written that register, and the
//   next request is accepted from then on.
//   One block is in the round unit at a time. The final round writes a result
//   register that holds until the receiver takes it; the next block runs
//   meanwhile and waits in its final round while that register is still full,
//   so a stalled receiver stalls the input after one further block.
//   cfg_ writes set round_count (clamped to 10..14 and to the key store).
//   Reset clears the controller and sets round_count to 10; the key store
//   is not cleared and must be loaded before use.
module aes_block_cipher #(
    parameter int KEY_WORDS = 60
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  aes_pkg::aes_in_t s_data,
    output logic             m_valid,
    input  logic             m_ready,
    output aes_pkg::aes_out_t m_data,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [3:0]       cfg_data
);
    import aes_pkg::*;

    localparam logic [3:0] ROUND_LIMIT = 4'(KEY_WORDS / 4 - 1);

    aes_cmd_t     cmd;
    logic         busy;
    logic         accept, start, key_we;
    logic [3:0]   rc_reg;
    logic [3:0]   rounds;
    logic [127:0] block_out;

    // Round count register.
    assign cfg_ready = 1'b1;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rc_reg <= ROUNDS_MIN;
        end else if (cfg_valid) begin
            rc_reg <= cfg_data;
        end
    end

    // Clamp the round count.
    always_comb begin
        rounds = rc_reg;
        if (rounds < ROUNDS_MIN) rounds = ROUNDS_MIN;
        if (rounds > ROUNDS_MAX) rounds = ROUNDS_MAX;
        if (rounds > ROUND_LIMIT) rounds = ROUND_LIMIT;
    end

    assign s_ready = !busy;
    assign accept  = s_valid && s_ready;
    assign start   = accept && (s_data.mode == MODE_ENCRYPT || s_data.mode == MODE_DECRYPT);
    assign key_we  = accept && (s_data.mode == MODE_LOAD) &&
                     ({26'd0, s_data.key_index} < KEY_WORDS);

    aes_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (start),
        .decrypt   (s_data.mode == MODE_DECRYPT),
        .rounds    (rounds),
        .out_taken (m_ready),
        .cmd       (cmd),
        .busy      (busy),
        .out_valid (m_valid)
    );

    aes_datapath #(.KEY_WORDS(KEY_WORDS)) u_dp (
        .aclk      (aclk),
        .key_we    (key_we),
        .key_index (s_data.key_index),
        .key_word  (s_data.key_word),
        .block_in  ({s_data.block_high, s_data.block_low}),
        .cmd       (cmd),
        .block_out (block_out)
    );

    assign m_data.result_high = block_out[127:64];
    assign m_data.result_low  = block_out[63:0];

`ifndef SYNTH
    // A request that is not a cipher request leaves the input open.
    a_load_open: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && !start |=> s_ready) else $error("input closed after a load request");
    // A cipher request leads to busy in the next cycle.
    a_start_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        start |=> !s_ready) else $error("cipher request did not start");
    // The result holds while stalled.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result changed under stall");
`endif
endmodule

@@ bench/aes_checker.sv @@
// Checker for the AES block cipher: watches the channels, predicts results and compares them.
module aes_checker (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    input  logic              s_ready,
    input  aes_pkg::aes_in_t  s_data,
    input  logic              m_valid,
    input  logic              m_ready,
    input  aes_pkg::aes_out_t m_data,
    input  logic              cfg_valid,
    input  logic              cfg_ready,
    input  logic [3:0]        cfg_data,
    output int                fail_count,
    output int                pending
);
    timeunit 1ns;
    timeprecision 1ps;

    import aes_pkg::*;

    localparam int         KEY_DEPTH = 60;
    localparam logic [7:0] POLY_LOW  = 8'h1b;

    typedef logic [7:0] state_t [16];

    logic [7:0]  sub_fwd [256];
    logic [7:0]  sub_inv [256];
    logic [31:0] key_store [KEY_DEPTH];
    logic [3:0]  rounds_reg;
    aes_out_t    expected_blocks [$];

    // Multiplication in GF(2^8) with the AES polynomial.
    function automatic logic [7:0] gf_product(input logic [7:0] a, input logic [7:0] b);
        logic [7:0] acc;
        logic [7:0] x;
        acc = 8'h00;
        x = a;
        for (int k = 0; k < 8; k++) begin
            if (b[k]) begin
                acc = acc ^ x;
            end
            x = {x[6:0], 1'b0} ^ (x[7] ? POLY_LOW : 8'h00);
        end
        return acc;
    endfunction

    // Round key word for column c of round r.
    function automatic logic [31:0] round_word(input int r, input int c);
        int idx;
        idx = r * 4 + c;
        return (idx < KEY_DEPTH) ? key_store[idx] : 32'h0;
    endfunction

    function automatic void add_round_key(ref state_t s, input int r);
        logic [31:0] w;
        for (int c = 0; c < 4; c++) begin
            w = round_word(r, c);
            for (int row = 0; row < 4; row++) begin
                s[4*c+row] = s[4*c+row] ^ w[31-8*row -: 8];
            end
        end
    endfunction

    function automatic void substitute(ref state_t s, input logic inverse);
        for (int i = 0; i < 16; i++) begin
            s[i] = inverse ? sub_inv[s[i]] : sub_fwd[s[i]];
        end
    endfunction

    // Row r rotates left by r columns going forward, right going back.
    function automatic void rotate_rows(ref state_t s, input logic inverse);
        state_t t;
        int src;
        t = s;
        for (int c = 0; c < 4; c++) begin
            for (int row = 0; row < 4; row++) begin
                src = inverse ? (c + 4 - row) % 4 : (c + row) % 4;
                s[4*c+row] = t[4*src+row];
            end
        end
    endfunction

    function automatic void mix_state(ref state_t s, input logic inverse);
        logic [7:0] coef [4];
        logic [7:0] col [4];
        logic [7:0] v;
        if (inverse) begin
            coef = '{8'h0e, 8'h0b, 8'h0d, 8'h09};
        end else begin
            coef = '{8'h02, 8'h03, 8'h01, 8'h01};
        end
        for (int c = 0; c < 4; c++) begin
            for (int row = 0; row < 4; row++) begin
                col[row] = s[4*c+row];
            end
            for (int row = 0; row < 4; row++) begin
                v = 8'h00;
                for (int t = 0; t < 4; t++) begin
                    v = v ^ gf_product(coef[(t + 4 - row) % 4], col[t]);
                end
                s[4*c+row] = v;
            end
        end
    endfunction

    // Encrypts or decrypts one request with the current keys and round count.
    function automatic aes_out_t cipher_block(input aes_in_t req);
        state_t s;
        aes_out_t res;
        int nr;
        logic inv;
        for (int i = 0; i < 8; i++) begin
            s[i]   = req.block_high[63-8*i -: 8];
            s[8+i] = req.block_low[63-8*i -: 8];
        end
        nr = rounds_reg;
        if (nr < 10) nr = 10;
        if (nr > 14) nr = 14;
        if (nr > KEY_DEPTH / 4 - 1) nr = KEY_DEPTH / 4 - 1;
        inv = (req.mode == MODE_DECRYPT);
        if (!inv) begin
            add_round_key(s, 0);
            for (int r = 1; r < nr; r++) begin
                substitute(s, 1'b0);
                rotate_rows(s, 1'b0);
                mix_state(s, 1'b0);
                add_round_key(s, r);
            end
            substitute(s, 1'b0);
            rotate_rows(s, 1'b0);
            add_round_key(s, nr);
        end else begin
            add_round_key(s, nr);
            for (int r = nr - 1; r > 0; r--) begin
                rotate_rows(s, 1'b1);
                substitute(s, 1'b1);
                add_round_key(s, r);
                mix_state(s, 1'b1);
            end
            rotate_rows(s, 1'b1);
            substitute(s, 1'b1);
            add_round_key(s, 0);
        end
        for (int i = 0; i < 8; i++) begin
            res.result_high[63-8*i -: 8] = s[i];
            res.result_low[63-8*i -: 8]  = s[8+i];
        end
        return res;
    endfunction

    // S-boxes from the field inverse and the affine map.
    initial begin
        logic [7:0] p;
        logic [7:0] b;
        for (int i = 0; i < 256; i++) begin
            p = 8'h01;
            if (i != 0) begin
                for (int k = 0; k < 254; k++) begin
                    p = gf_product(p, i[7:0]);
                end
            end else begin
                p = 8'h00;
            end
            b = p ^ {p[6:0], p[7]} ^ {p[5:0], p[7:6]} ^ {p[4:0], p[7:5]}
                ^ {p[3:0], p[7:4]} ^ 8'h63;
            sub_fwd[i] = b;
            sub_inv[b] = i[7:0];
        end
    end

    // Configuration, request and result handshakes, sampled at the rising edge.
    always @(posedge aclk) begin
        aes_out_t exp_res;
        if (!aresetn) begin
            rounds_reg = 4'd10;
            expected_blocks.delete();
        end else begin
            if (cfg_valid && cfg_ready) begin
                rounds_reg = cfg_data;
            end
            if (m_valid && m_ready) begin
                if (expected_blocks.size() == 0) begin
                    fail_count++;
                    if (fail_count <= 10) begin
                        $display("unexpected result %h %h", m_data.result_high,
                                 m_data.result_low);
                    end
                end else begin
                    exp_res = expected_blocks.pop_front();
                    if (exp_res.result_high !== m_data.result_high) begin
                        fail_count++;
                        if (fail_count <= 10) begin
                            $display("result_high mismatch: expected %h actual %h",
                                     exp_res.result_high, m_data.result_high);
                        end
                    end
                    if (exp_res.result_low !== m_data.result_low) begin
                        fail_count++;
                        if (fail_count <= 10) begin
                            $display("result_low mismatch: expected %h actual %h",
                                     exp_res.result_low, m_data.result_low);
                        end
                    end
                end
            end
            if (s_valid && s_ready) begin
                case (s_data.mode)
                    MODE_LOAD: begin
                        if (s_data.key_index < KEY_DEPTH) begin
                            key_store[s_data.key_index] = s_data.key_word;
                        end
                    end
                    MODE_ENCRYPT, MODE_DECRYPT: begin
                        expected_blocks.push_back(cipher_block(s_data));
                    end
                    default: begin
                    end
                endcase
            end
        end
        pending = expected_blocks.size();
    end

    initial fail_count = 0;
    initial pending = 0;

endmodule

@@ bench/tb_aes_block_cipher.sv @@
// Testbench top for the AES block cipher: clock, reset, stimulus and verdict.
module tb_aes_block_cipher;
    timeunit 1ns;
    timeprecision 1ps;

    import aes_pkg::*;

    localparam logic [1:0] MODE_UNUSED = 2'd3;

    logic      aclk;
    logic      aresetn;
    logic      s_valid;
    logic      s_ready;
    aes_in_t   s_data;
    logic      m_valid;
    logic      m_ready;
    aes_out_t  m_data;
    logic      cfg_valid;
    logic      cfg_ready;
    logic [3:0] cfg_data;
    int        fail_count;
    int        pending;
    logic      calm;

    aes_block_cipher u_top (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
    );

    aes_checker u_checker (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
        .fail_count(fail_count), .pending(pending)
    );

    // 20 ns clock.
    initial aclk = 1'b0;
    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // Receiver stalls about a quarter of the time, except in calm stretches.
    always @(negedge aclk) begin
        m_ready = calm || ($urandom_range(99) >= 26);
    end

    // Issues one request and holds it until accepted, then sometimes a random gap.
    task automatic send_req(input aes_in_t req);
        s_data = req;
        s_valid = 1'b1;
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
        if (!calm && $urandom_range(99) < 26) begin
            s_valid = 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge aclk);
        end
    endtask

    task automatic send_key(input int idx, input logic [31:0] w);
        aes_in_t req;
        req = '{mode: MODE_LOAD, key_index: idx[5:0], key_word: w,
                block_high: {$urandom, $urandom}, block_low: {$urandom, $urandom}};
        send_req(req);
    endtask

    task automatic send_block(input logic [1:0] md, input logic [63:0] hi,
                              input logic [63:0] lo);
        aes_in_t req;
        req = '{mode: md, key_index: 6'($urandom_range(63)), key_word: $urandom,
                block_high: hi, block_low: lo};
        send_req(req);
    endtask

    // Round count is written only once every result is out and the core is quiet.
    task automatic set_rounds(input logic [3:0] v);
        s_valid = 1'b0;
        while (pending != 0) @(negedge aclk);
        repeat (20) @(negedge aclk);
        cfg_data = v;
        cfg_valid = 1'b1;
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
        cfg_valid = 1'b0;
    endtask

    task automatic random_block;
        int pick;
        pick = $urandom_range(99);
        if (pick < 40) begin
            send_block(MODE_ENCRYPT, {$urandom, $urandom}, {$urandom, $urandom});
        end else if (pick < 75) begin
            send_block(MODE_DECRYPT, {$urandom, $urandom}, {$urandom, $urandom});
        end else if (pick < 95) begin
            send_key($urandom_range(63), $urandom);
        end else begin
            send_block(MODE_UNUSED, {$urandom, $urandom}, {$urandom, $urandom});
        end
    endtask

    initial begin
        logic [3:0] settings [8];
        settings = '{4'd12, 4'd14, 4'd0, 4'd15, 4'd11, 4'd13, 4'd9, 4'd10};
        calm = 1'b0;
        s_valid = 1'b0;
        s_data = '0;
        cfg_valid = 1'b0;
        cfg_data = 4'd0;
        m_ready = 1'b0;
        aresetn = 1'b0;
        repeat (7) @(negedge aclk);
        aresetn = 1'b1;

        // Fill the whole key store before any cipher request reads it.
        for (int i = 0; i < 60; i++) begin
            send_key(i, $urandom);
        end

        // Directed: field extremes, both directions, ignored loads and the unused mode.
        send_block(MODE_ENCRYPT, 64'h0, 64'h0);
        send_block(MODE_DECRYPT, 64'h0, 64'h0);
        send_block(MODE_ENCRYPT, '1, '1);
        send_block(MODE_DECRYPT, '1, '1);
        send_block(MODE_ENCRYPT, 64'h0123456789abcdef, 64'hfedcba9876543210);
        send_block(MODE_DECRYPT, 64'haaaaaaaaaaaaaaaa, 64'h5555555555555555);
        send_block(MODE_UNUSED, '1, '1);
        send_key(60, 32'hffffffff);
        send_key(63, 32'h0);
        send_key(0, 32'h0);
        send_key(59, 32'hffffffff);
        send_block(MODE_ENCRYPT, 64'h00112233_44556677, 64'h8899aabb_ccddeeff);
        send_block(MODE_DECRYPT, 64'h00112233_44556677, 64'h8899aabb_ccddeeff);
        set_rounds(4'd14);
        send_block(MODE_ENCRYPT, '1, 64'h0);
        send_block(MODE_DECRYPT, 64'h0, '1);

        // Random phases across round-count settings, one stretch without stalls.
        for (int ph = 0; ph < 8; ph++) begin
            set_rounds(settings[ph]);
            calm = (ph == 3);
            for (int n = 0; n < 142; n++) begin
                random_block();
            end
            calm = 1'b0;
        end
        s_valid = 1'b0;

        while (pending != 0) @(negedge aclk);
        repeat (30) @(negedge aclk);
        if (fail_count == 0) begin
            $display("aes_block_cipher regression: pass");
        end else begin
            $display("aes_block_cipher regression: fail");
        end
        $finish;
    end

    // Watchdog.
    initial begin
        #20ms;
        $display("aes_block_cipher regression: fail");
        $finish;
    end

endmodule
